### hw/rtl/evg_pkg.sv
package evg_pkg;

  // Field widths
  localparam int CNT_W      = 11;
  localparam int RAD_W      = 16;
  localparam int POS_W      = 17;
  localparam int NRM_W      = 16;
  localparam int TEX_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Largest accepted sector or stack count
  localparam int MAX_SEGMENTS = 1024;

  // Quarter-wave sine polynomial coefficients, Q14
  localparam int SIN_A = 51472;
  localparam int SIN_B = 21024;
  localparam int SIN_C = 2320;

  // Register reset values
  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [CNT_W-1:0] SECTOR_RST = 11'd36;
  localparam logic [CNT_W-1:0] STACK_RST  = 11'd18;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_X     = 3'd0,
    REG_RADIUS_Y     = 3'd1,
    REG_RADIUS_Z     = 3'd2,
    REG_SECTOR_COUNT = 3'd3,
    REG_STACK_COUNT  = 3'd4
  } cfg_reg_t;

endpackage

### hw/rtl/ellipsoid_vertex_generator_unit.sv
// Ellipsoid vertex generator. Each grid point (stack_index, sector_index) gives one vertex:
// position scaled by the three radii (signed Q8.8), unit normal (signed Q1.14) and texture
// coordinates (Q1.16). A point past its count, or a count of zero or above 1024, returns
// index_error with all other fields zero. Unless the output stalls, the block takes one word
// per clock and returns one vertex per clock. The pipeline has 79 register stages: 17 stages
// of index-over-count division (one quotient bit each), 4 sine polynomial stages, 4 multiply
// stages, 6 normalize stages, a 32-stage square root (one root bit each), 15 stages of normal
// division and the output register. A stall on the output holds only the stages that are
// full; empty stages keep filling. Registers are written through the configuration port,
// which is always ready, and must be written only while no vertex is in flight.
module ellipsoid_vertex_generator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [evg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [evg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [evg_pkg::CNT_W-1:0]           stack_index,
  input  logic [evg_pkg::CNT_W-1:0]           sector_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [evg_pkg::POS_W-1:0]    pos_x,
  output logic signed [evg_pkg::POS_W-1:0]    pos_y,
  output logic signed [evg_pkg::POS_W-1:0]    pos_z,
  output logic signed [evg_pkg::NRM_W-1:0]    norm_x,
  output logic signed [evg_pkg::NRM_W-1:0]    norm_y,
  output logic signed [evg_pkg::NRM_W-1:0]    norm_z,
  output logic [evg_pkg::TEX_W-1:0]           tex_u,
  output logic [evg_pkg::TEX_W-1:0]           tex_v,
  output logic                                index_error
);
  import evg_pkg::*;

  // Stage map
  localparam int TDIV_N   = 17;
  localparam int SIN_N    = 4;
  localparam int PROD_N   = 4;
  localparam int NORM_N   = 6;
  localparam int SQRT_N   = 32;
  localparam int NDIV_N   = 15;
  localparam int ST_TDIV  = 0;
  localparam int ST_SIN   = ST_TDIV + TDIV_N;
  localparam int ST_PROD  = ST_SIN + SIN_N;
  localparam int ST_NORM  = ST_PROD + PROD_N;
  localparam int ST_SQRT  = ST_NORM + NORM_N;
  localparam int ST_NDIV  = ST_SQRT + SQRT_N;
  localparam int ST_OUT   = ST_NDIV + NDIV_N;
  localparam int N_STAGES = ST_OUT + 1;

  localparam int TD_W  = 29;
  localparam int TQ_W  = 17;
  localparam int SQ_W  = 64;
  localparam int MN_W  = 30;
  localparam int LEN_W = 31;
  localparam int ND_W  = 45;
  localparam int NQ_W  = 15;
  localparam int MAG_W = 47;
  localparam int A_W   = 48;

  localparam logic [15:0] PH_QUARTER = 16'h4000;

  // Fields that ride along the pipeline
  typedef struct packed {
    logic                    err;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [2:0]              nsign;
    logic                    nzero;
  } side_t;

  // Round half away from zero, then shift right by s
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // Configuration registers
  logic [RAD_W-1:0] radius_x, radius_y, radius_z;
  logic [CNT_W-1:0] sector_count, stack_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x     <= RADIUS_RST;
      radius_y     <= RADIUS_RST;
      radius_z     <= RADIUS_RST;
      sector_count <= SECTOR_RST;
      stack_count  <= STACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS_X:     radius_x     <= cfg_data;
        REG_RADIUS_Y:     radius_y     <= cfg_data;
        REG_RADIUS_Z:     radius_z     <= cfg_data;
        REG_SECTOR_COUNT: sector_count <= cfg_data[CNT_W-1:0];
        REG_STACK_COUNT:  stack_count  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [RAD_W:0] rx_s, ry_s, rz_s;
  assign rx_s = $signed({1'b0, radius_x});
  assign ry_s = $signed({1'b0, radius_y});
  assign rz_s = $signed({1'b0, radius_z});

  // Stage valids and advance chain
  logic [N_STAGES-1:0] vld;
  logic [N_STAGES:0]   adv;

  always_comb begin
    adv[N_STAGES] = !out_stall;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < N_STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Index check
  logic err_in;
  assign err_in = (sector_count == '0) || (stack_count == '0) ||
                  (sector_count > CNT_W'(MAX_SEGMENTS)) ||
                  (stack_count > CNT_W'(MAX_SEGMENTS)) ||
                  (stack_index > stack_count) || (sector_index > sector_count);

  // Index-over-count dividers: u, v, stack phase
  logic [TD_W-1:0]  td_num [3];
  logic [CNT_W:0]   td_den [3];
  logic [TD_W-1:0]  td_rem [TDIV_N][3];
  logic [TQ_W-1:0]  td_q   [TDIV_N][3];

  assign td_num[0] = TD_W'({sector_index, 17'b0}) + TD_W'(sector_count);
  assign td_num[1] = TD_W'({stack_index, 17'b0}) + TD_W'(stack_count);
  assign td_num[2] = TD_W'({stack_index, 16'b0}) + TD_W'(stack_count);
  assign td_den[0] = {sector_count, 1'b0};
  assign td_den[1] = {stack_count, 1'b0};
  assign td_den[2] = {stack_count, 1'b0};

  for (genvar s = 0; s < TDIV_N; s++) begin : g_td
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [TD_W-1:0] r_in, dsh;
      logic [TQ_W-1:0] q_in;
      logic            take;
      if (s == 0) begin : g_first
        assign r_in = td_num[l];
        assign q_in = '0;
      end else begin : g_next
        assign r_in = td_rem[s-1][l];
        assign q_in = td_q[s-1][l];
      end
      assign dsh  = TD_W'(td_den[l]) << (TQ_W - 1 - s);
      assign take = (r_in >= dsh);
      always_ff @(posedge clk) begin
        if (adv[ST_TDIV+s]) begin
          td_rem[s][l] <= take ? r_in - dsh : r_in;
          td_q[s][l]   <= take ? (q_in | (TQ_W'(1) << (TQ_W - 1 - s))) : q_in;
        end
      end
    end
  end

  // Sine lanes: cos stack, sin stack, cos sector, sin sector
  logic [15:0] ph_se, ph_st;
  logic [15:0] sin_ph [4];

  assign ph_se     = td_q[TDIV_N-1][0][15:0];
  assign ph_st     = PH_QUARTER - td_q[TDIV_N-1][2][15:0];
  assign sin_ph[0] = ph_st + PH_QUARTER;
  assign sin_ph[1] = ph_st;
  assign sin_ph[2] = ph_se + PH_QUARTER;
  assign sin_ph[3] = ph_se;

  logic [14:0]        s1_x [4], s1_x2 [4], s2_x [4], s2_x2 [4], s2_y1 [4], s3_x [4];
  logic               s1_neg [4], s2_neg [4], s3_neg [4];
  logic [15:0]        s3_y2 [4];
  logic signed [15:0] s4_v [4];
  logic [14:0]        x_c [4], x2_c [4], y1_c [4];
  logic [15:0]        y2_c [4];
  logic signed [15:0] v_c [4];

  always_comb begin
    logic [29:0] pxx;
    logic [26:0] pc;
    logic [29:0] py;
    logic [30:0] pr;
    for (int l = 0; l < 4; l++) begin
      x_c[l]  = sin_ph[l][14] ? 15'(15'd16384 - {1'b0, sin_ph[l][13:0]})
                              : {1'b0, sin_ph[l][13:0]};
      pxx     = 30'(x_c[l]) * 30'(x_c[l]);
      x2_c[l] = pxx[28:14];
      pc      = 27'(s1_x2[l]) * 27'(SIN_C);
      y1_c[l] = 15'(SIN_B) - 15'(pc[26:14]);
      py      = 30'(s2_x2[l]) * 30'(s2_y1[l]);
      y2_c[l] = 16'(SIN_A) - py[29:14];
      pr      = 31'(s3_x[l]) * 31'(s3_y2[l]);
      v_c[l]  = s3_neg[l] ? -$signed(pr[30:15]) : $signed(pr[30:15]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (adv[ST_SIN]) begin
        s1_x[l]   <= x_c[l];
        s1_neg[l] <= sin_ph[l][15];
        s1_x2[l]  <= x2_c[l];
      end
      if (adv[ST_SIN+1]) begin
        s2_x[l]   <= s1_x[l];
        s2_neg[l] <= s1_neg[l];
        s2_x2[l]  <= s1_x2[l];
        s2_y1[l]  <= y1_c[l];
      end
      if (adv[ST_SIN+2]) begin
        s3_x[l]   <= s2_x[l];
        s3_neg[l] <= s2_neg[l];
        s3_y2[l]  <= y2_c[l];
      end
      if (adv[ST_SIN+3]) s4_v[l] <= v_c[l];
    end
  end

  // Products: position and normal direction
  logic signed [31:0]  p1_csse, p1_cssn;
  logic signed [32:0]  p1_pzr, p1_snrx;
  logic signed [48:0]  p2_pxr, p2_pyr;
  logic signed [15:0]  p2_ux, p2_uy;
  logic signed [16:0]  p2_pz;
  logic signed [A_W-1:0] p2_a2, p3_a2, p4_a0, p4_a1, p4_a2;
  logic signed [32:0]  p3_ux_ry, p3_uy_rx;

  always_ff @(posedge clk) begin
    if (adv[ST_PROD]) begin
      p1_csse <= 32'(s4_v[0]) * 32'(s4_v[2]);
      p1_cssn <= 32'(s4_v[0]) * 32'(s4_v[3]);
      p1_pzr  <= 33'(s4_v[1]) * 33'(rz_s);
      p1_snrx <= 33'(s4_v[1]) * 33'(rx_s);
    end
    if (adv[ST_PROD+1]) begin
      p2_pxr <= 49'(p1_csse) * 49'(rx_s);
      p2_pyr <= 49'(p1_cssn) * 49'(ry_s);
      p2_ux  <= 16'(rnd_sh(64'(p1_csse), 14));
      p2_uy  <= 16'(rnd_sh(64'(p1_cssn), 14));
      p2_pz  <= 17'(rnd_sh(64'(p1_pzr), 14));
      p2_a2  <= A_W'(p1_snrx) * A_W'(ry_s);
    end
    if (adv[ST_PROD+2]) begin
      p3_ux_ry <= 33'(p2_ux) * 33'(ry_s);
      p3_uy_rx <= 33'(p2_uy) * 33'(rx_s);
      p3_a2    <= p2_a2;
    end
    if (adv[ST_PROD+3]) begin
      p4_a0 <= A_W'(p3_ux_ry) * A_W'(rz_s);
      p4_a1 <= A_W'(p3_uy_rx) * A_W'(rz_s);
      p4_a2 <= p3_a2;
    end
  end

  // Normalize: magnitude, max, leading one, scale to [2^29, 2^30)
  logic [MAG_W-1:0] n1_m [3], n2_m [3], n3_m [3];
  logic [MAG_W-1:0] n2_mx;
  logic [5:0]       n3_p;
  logic [MN_W-1:0]  n4_m [3], n5_m [3], n6_m [3];
  logic [59:0]      n5_sq [3];
  logic [61:0]      n6_sum;
  logic [MAG_W-1:0] mx_c;
  logic [5:0]       p_c;
  logic [MN_W-1:0]  ms_c [3];

  always_comb begin
    logic [MAG_W+MN_W-2:0] w;
    mx_c = n1_m[0];
    if (n1_m[1] > mx_c) mx_c = n1_m[1];
    if (n1_m[2] > mx_c) mx_c = n1_m[2];
    p_c = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (n2_mx[b]) p_c = 6'(b);
    end
    for (int k = 0; k < 3; k++) begin
      w = {n3_m[k], 29'b0} >> n3_p;
      ms_c[k] = w[MN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_NORM]) begin
      n1_m[0] <= p4_a0[A_W-1] ? MAG_W'(-p4_a0) : MAG_W'(p4_a0);
      n1_m[1] <= p4_a1[A_W-1] ? MAG_W'(-p4_a1) : MAG_W'(p4_a1);
      n1_m[2] <= p4_a2[A_W-1] ? MAG_W'(-p4_a2) : MAG_W'(p4_a2);
    end
    if (adv[ST_NORM+1]) begin
      n2_mx <= mx_c;
      n2_m  <= n1_m;
    end
    if (adv[ST_NORM+2]) begin
      n3_p <= p_c;
      n3_m <= n2_m;
    end
    if (adv[ST_NORM+3]) n4_m <= ms_c;
    if (adv[ST_NORM+4]) begin
      for (int k = 0; k < 3; k++) n5_sq[k] <= 60'(n4_m[k]) * 60'(n4_m[k]);
      n5_m <= n4_m;
    end
    if (adv[ST_NORM+5]) begin
      n6_sum <= 62'(n5_sq[0]) + 62'(n5_sq[1]) + 62'(n5_sq[2]);
      n6_m   <= n5_m;
    end
  end

  // Square root, one root bit per stage
  logic [SQ_W-1:0] sq_v [SQRT_N];
  logic [SQ_W-1:0] sq_r [SQRT_N];
  logic [MN_W-1:0] sq_m [SQRT_N][3];

  for (genvar s = 0; s < SQRT_N; s++) begin : g_sq
    logic [SQ_W-1:0] v_in, r_in, t;
    logic [MN_W-1:0] m_in [3];
    logic            take;
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_N - 1 - s));
    if (s == 0) begin : g_first
      assign v_in = SQ_W'(n6_sum);
      assign r_in = '0;
      assign m_in = n6_m;
    end else begin : g_next
      assign v_in = sq_v[s-1];
      assign r_in = sq_r[s-1];
      assign m_in = sq_m[s-1];
    end
    assign t    = r_in + BIT;
    assign take = (v_in >= t);
    always_ff @(posedge clk) begin
      if (adv[ST_SQRT+s]) begin
        sq_v[s] <= take ? v_in - t : v_in;
        sq_r[s] <= take ? (r_in >> 1) + BIT : (r_in >> 1);
        sq_m[s] <= m_in;
      end
    end
  end

  // Normal divider: component * 2^14 over length, rounded
  logic [ND_W-1:0]  nd_rem [NDIV_N][3];
  logic [NQ_W-1:0]  nd_q   [NDIV_N][3];
  logic [LEN_W-1:0] nd_len [NDIV_N];
  logic [LEN_W-1:0] len_c;

  assign len_c = sq_r[SQRT_N-1][LEN_W-1:0];

  for (genvar s = 0; s < NDIV_N; s++) begin : g_nd
    logic [LEN_W-1:0] l_in;
    if (s == 0) begin : g_first
      assign l_in = len_c;
    end else begin : g_next
      assign l_in = nd_len[s-1];
    end
    always_ff @(posedge clk) begin
      if (adv[ST_NDIV+s]) nd_len[s] <= l_in;
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [ND_W-1:0] r_in, dsh;
      logic [NQ_W-1:0] q_in;
      logic            take;
      if (s == 0) begin : g_first
        assign r_in = ND_W'({sq_m[SQRT_N-1][l], 14'b0}) + ND_W'(len_c[LEN_W-1:1]);
        assign q_in = '0;
      end else begin : g_next
        assign r_in = nd_rem[s-1][l];
        assign q_in = nd_q[s-1][l];
      end
      assign dsh  = ND_W'(l_in) << (NQ_W - 1 - s);
      assign take = (r_in >= dsh);
      always_ff @(posedge clk) begin
        if (adv[ST_NDIV+s]) begin
          nd_rem[s][l] <= take ? r_in - dsh : r_in;
          nd_q[s][l]   <= take ? (q_in | (NQ_W'(1) << (NQ_W - 1 - s))) : q_in;
        end
      end
    end
  end

  // Side fields along the pipe
  side_t sd    [ST_OUT];
  side_t sd_in [ST_OUT];

  always_comb begin
    sd_in[0]     = '0;
    sd_in[0].err = err_in;
    for (int k = 1; k < ST_OUT; k++) sd_in[k] = sd[k-1];
    sd_in[ST_SIN].tex_u        = td_q[TDIV_N-1][0];
    sd_in[ST_SIN].tex_v        = td_q[TDIV_N-1][1];
    sd_in[ST_PROD+2].pos_x     = POS_W'(rnd_sh(64'(p2_pxr), 28));
    sd_in[ST_PROD+2].pos_y     = POS_W'(rnd_sh(64'(p2_pyr), 28));
    sd_in[ST_PROD+2].pos_z     = p2_pz;
    sd_in[ST_NORM].nsign       = {p4_a2[A_W-1], p4_a1[A_W-1], p4_a0[A_W-1]};
    sd_in[ST_NORM+2].nzero     = (n2_mx == '0);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ST_OUT; k++) begin
      if (adv[k]) sd[k] <= sd_in[k];
    end
  end

  // Output register
  logic signed [NRM_W-1:0] nrm_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (sd[ST_OUT-1].nzero) begin
        nrm_c[k] = '0;
      end else if (sd[ST_OUT-1].nsign[k]) begin
        nrm_c[k] = -$signed({1'b0, nd_q[NDIV_N-1][k]});
      end else begin
        nrm_c[k] = $signed({1'b0, nd_q[NDIV_N-1][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      if (sd[ST_OUT-1].err) begin
        pos_x       <= '0;
        pos_y       <= '0;
        pos_z       <= '0;
        norm_x      <= '0;
        norm_y      <= '0;
        norm_z      <= '0;
        tex_u       <= '0;
        tex_v       <= '0;
        index_error <= 1'b1;
      end else begin
        pos_x       <= sd[ST_OUT-1].pos_x;
        pos_y       <= sd[ST_OUT-1].pos_y;
        pos_z       <= sd[ST_OUT-1].pos_z;
        norm_x      <= nrm_c[0];
        norm_y      <= nrm_c[1];
        norm_z      <= nrm_c[2];
        tex_u       <= sd[ST_OUT-1].tex_u;
        tex_v       <= sd[ST_OUT-1].tex_v;
        index_error <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/evg_checker.sv
module evg_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [evg_pkg::POS_W-1:0] pos_x,
  input logic signed [evg_pkg::POS_W-1:0] pos_y,
  input logic signed [evg_pkg::POS_W-1:0] pos_z,
  input logic signed [evg_pkg::NRM_W-1:0] norm_x,
  input logic signed [evg_pkg::NRM_W-1:0] norm_y,
  input logic signed [evg_pkg::NRM_W-1:0] norm_z,
  input logic [evg_pkg::TEX_W-1:0]        tex_u,
  input logic [evg_pkg::TEX_W-1:0]        tex_v,
  input logic                             index_error
);
  import evg_pkg::*;

  // A stalled output word stays valid and its pos_x, norm_x, tex_u and index_error hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(norm_x) &&
      $stable(tex_u) && $stable(index_error))
    else $error("output word changed under stall");

  // Rejected grid point carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> pos_x == '0 && pos_y == '0 && pos_z == '0 &&
      norm_x == '0 && norm_y == '0 && norm_z == '0 && tex_u == '0 && tex_v == '0)
    else $error("index error with nonzero fields");

  // Texture coordinates never exceed one
  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
    else $error("texture coordinate above one");

  // Normal components stay within unit range
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_x >= -16'sd16384 && norm_x <= 16'sd16384 &&
      norm_y >= -16'sd16384 && norm_y <= 16'sd16384 &&
      norm_z >= -16'sd16384 && norm_z <= 16'sd16384)
    else $error("normal component out of range");

endmodule

bind ellipsoid_vertex_generator_unit evg_checker u_evg_checker (.*);
